/* rtl/core/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define HBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");
`else
`define HBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define HBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/hbs_pkg.sv */
// types and constants of the heightmap sampler
package hbs_pkg;

	localparam int OP_W   = 2;
	localparam int MAP_W  = 10;
	localparam int VAL_W  = 8;
	localparam int PCT_W  = 7;
	localparam int EXP_W  = 4;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 10;

	// grid size limits and fixed-point unit, all powers of two are assumed
	localparam int MAX_X_EXP = 8;
	localparam int MAX_Y_EXP = 8;
	localparam int FIX_ONE   = 1024;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_PCTL   = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_X_EXP  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_Y_EXP  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_MAP_W  = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_MAP_H  = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_PMODE  = 3'd4;

	// register reset values
	localparam logic [EXP_W-1:0] RST_X_EXP = 4'd7;
	localparam logic [EXP_W-1:0] RST_Y_EXP = 4'd6;
	localparam logic [MAP_W-1:0] RST_MAP_W = 10'd64;
	localparam logic [MAP_W-1:0] RST_MAP_H = 10'd64;

	localparam int HEIGHT_MAX = 255;
	localparam int PCT_MAX    = 100;
	// x / 100 as (x * RECIP_100) >> RECIP_SH, exact for x below 25600
	localparam int RECIP_100  = 5243;
	localparam int RECIP_SH   = 19;

	typedef struct packed {
		logic clr_we;
		logic div_start;
		logic cap;
		logic ld_we;
		logic smp_mul;
		logic smp_wt;
		logic smp_rd;
		logic smp_fin;
		logic pct_init;
		logic scan_init;
		logic scan_rd;
		logic pct_upd;
		logic pct_out;
	} hbs_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic rk_last;
		logic scan_last;
		logic est_eq_lo;
		logic out_free;
	} hbs_stat_t;

endpackage

/* rtl/core/hbs_ctrl.sv */
// controller state machine of the heightmap sampler
module hbs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [hbs_pkg::OP_W-1:0]  op,
	input  logic                      cfg_valid,
	input  hbs_pkg::hbs_stat_t        stat,
	output logic                      in_stall,
	output logic                      cfg_ready,
	output hbs_pkg::hbs_cmd_t         cmd
);
	import hbs_pkg::*;

	typedef enum logic [13:0] {
		ST_CLR    = 14'b00000000000001,
		ST_IDLE   = 14'b00000000000010,
		ST_DIV    = 14'b00000000000100,
		ST_SMUL   = 14'b00000000001000,
		ST_SWT    = 14'b00000000010000,
		ST_SRD    = 14'b00000000100000,
		ST_SACC   = 14'b00000001000000,
		ST_SFIN   = 14'b00000010000000,
		ST_PINIT  = 14'b00000100000000,
		ST_PCHK   = 14'b00001000000000,
		ST_PSCAN  = 14'b00010000000000,
		ST_PDRAIN = 14'b00100000000000,
		ST_PUPD   = 14'b01000000000000,
		ST_POUT   = 14'b10000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   dirty_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = (state_q == ST_IDLE) || (state_q == ST_CLR);
		case (state_q)
			ST_CLR: begin
				cmd.clr_we = 1'b1;
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (!cfg_valid) begin
					if (dirty_q) begin
						cmd.div_start = 1'b1;
						state_nxt     = ST_DIV;
					end else begin
						in_stall = 1'b0;
						if (in_valid) begin
							cmd.cap = 1'b1;
							case (op)
								OP_LOAD:   cmd.ld_we = 1'b1;
								OP_SAMPLE: state_nxt = ST_SMUL;
								OP_PCTL:   state_nxt = ST_PINIT;
								default:   state_nxt = ST_IDLE;
							endcase
						end
					end
				end
			end
			ST_DIV: begin
				if (!stat.div_busy) state_nxt = ST_IDLE;
			end
			ST_SMUL: begin
				cmd.smp_mul = 1'b1;
				state_nxt   = ST_SWT;
			end
			ST_SWT: begin
				cmd.smp_wt = 1'b1;
				state_nxt  = ST_SRD;
			end
			ST_SRD: begin
				cmd.smp_rd = 1'b1;
				if (stat.rk_last) state_nxt = ST_SACC;
			end
			ST_SACC: state_nxt = ST_SFIN;
			ST_SFIN: begin
				if (stat.out_free) begin
					cmd.smp_fin = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			ST_PINIT: begin
				cmd.pct_init = 1'b1;
				state_nxt    = ST_PCHK;
			end
			ST_PCHK: begin
				if (stat.est_eq_lo) begin
					state_nxt = ST_POUT;
				end else begin
					cmd.scan_init = 1'b1;
					state_nxt     = ST_PSCAN;
				end
			end
			ST_PSCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) state_nxt = ST_PDRAIN;
			end
			ST_PDRAIN: state_nxt = ST_PUPD;
			ST_PUPD: begin
				cmd.pct_upd = 1'b1;
				state_nxt   = ST_PCHK;
			end
			ST_POUT: begin
				if (stat.out_free) begin
					cmd.pct_out = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state and pending step recompute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			dirty_q <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) dirty_q <= 1'b1;
			else if (cmd.div_start) dirty_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/hbs_dp.sv */
// datapath of the heightmap sampler: registers, grid memory, divider, blend and scan
module hbs_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hbs_pkg::hbs_cmd_t           cmd,
	output hbs_pkg::hbs_stat_t          stat,
	input  logic                        cfg_we,
	input  logic [hbs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [hbs_pkg::CDAT_W-1:0]  cfg_data,
	input  logic [hbs_pkg::MAP_W-1:0]   pos_x,
	input  logic [hbs_pkg::MAP_W-1:0]   pos_y,
	input  logic [hbs_pkg::VAL_W-1:0]   cell_value,
	input  logic [hbs_pkg::PCT_W-1:0]   percent,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [hbs_pkg::VAL_W-1:0]   result_value
);
	import hbs_pkg::*;

	localparam int FB     = $clog2(FIX_ONE);
	localparam int MAXE   = (MAX_X_EXP > MAX_Y_EXP) ? MAX_X_EXP : MAX_Y_EXP;
	localparam int DW     = MAXE + FB + 1;
	localparam int CNTW   = $clog2(DW + 1);
	localparam int GXW    = MAX_X_EXP + 1;
	localparam int GYW    = MAX_Y_EXP + 1;
	localparam int STRIDE = (1 << MAX_Y_EXP) + 1;
	localparam int CELLS  = ((1 << MAX_X_EXP) + 1) * STRIDE;
	localparam int AW     = $clog2(CELLS);
	localparam int SXW    = DW + MAP_W;
	localparam int WW     = FB + 1;
	localparam int PW     = 2 * WW;
	localparam int ACCW   = PW + VAL_W + 2;
	localparam int CW     = MAX_X_EXP + MAX_Y_EXP + 1;
	localparam int SHW    = CW + 7;
	localparam int EPW    = 28;

	// configuration registers
	logic [EXP_W-1:0] gxe_q, gye_q;
	logic [MAP_W-1:0] mw_q, mh_q;
	logic             pmode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gxe_q   <= RST_X_EXP;
			gye_q   <= RST_Y_EXP;
			mw_q    <= RST_MAP_W;
			mh_q    <= RST_MAP_H;
			pmode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_EXP: gxe_q   <= cfg_data[EXP_W-1:0];
				CFG_Y_EXP: gye_q   <= cfg_data[EXP_W-1:0];
				CFG_MAP_W: mw_q    <= cfg_data[MAP_W-1:0];
				CFG_MAP_H: mh_q    <= cfg_data[MAP_W-1:0];
				CFG_PMODE: pmode_q <= cfg_data[0];
				default:   pmode_q <= pmode_q;
			endcase
		end
	end

	// saturated exponents, grid sizes, map spans
	logic [EXP_W-1:0] xe_c, ye_c;
	logic [GXW-1:0]   gx;
	logic [GYW-1:0]   gy;
	logic [MAP_W-1:0] sw, sh;

	always_comb begin
		if (gxe_q == '0) xe_c = EXP_W'(1);
		else if (gxe_q > EXP_W'(MAX_X_EXP)) xe_c = EXP_W'(MAX_X_EXP);
		else xe_c = gxe_q;
		if (gye_q == '0) ye_c = EXP_W'(1);
		else if (gye_q > EXP_W'(MAX_Y_EXP)) ye_c = EXP_W'(MAX_Y_EXP);
		else ye_c = gye_q;
		gx = GXW'(1) << xe_c;
		gy = GYW'(1) << ye_c;
		sw = (mw_q == '0) ? MAP_W'(1) : mw_q;
		sh = (mh_q == '0) ? MAP_W'(1) : mh_q;
	end

	// step dividers, one quotient bit per cycle
	logic [DW-1:0]    numx_q, numy_q, x_step_q, y_step_q;
	logic [MAP_W-1:0] remx_q, remy_q;
	logic [CNTW-1:0]  div_cnt_q;
	logic [MAP_W:0]   rx2, ry2;
	logic             qx, qy;

	always_comb begin
		rx2 = {remx_q, numx_q[DW-1]};
		ry2 = {remy_q, numy_q[DW-1]};
		qx  = (rx2 >= {1'b0, sw});
		qy  = (ry2 >= {1'b0, sh});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_cnt_q <= '0;
		else if (cmd.div_start) div_cnt_q <= CNTW'(DW);
		else if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - CNTW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			numx_q <= DW'(1) << (int'(xe_c) + FB);
			numy_q <= DW'(1) << (int'(ye_c) + FB);
			remx_q <= '0;
			remy_q <= '0;
		end else if (div_cnt_q != '0) begin
			numx_q   <= numx_q << 1;
			numy_q   <= numy_q << 1;
			remx_q   <= qx ? MAP_W'(rx2 - {1'b0, sw}) : rx2[MAP_W-1:0];
			remy_q   <= qy ? MAP_W'(ry2 - {1'b0, sh}) : ry2[MAP_W-1:0];
			x_step_q <= {x_step_q[DW-2:0], qx};
			y_step_q <= {y_step_q[DW-2:0], qy};
		end
	end

	// input transaction capture with clamping
	logic [MAP_W-1:0] px_q, py_q;
	logic [PCT_W-1:0] pct_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			px_q  <= (pos_x > sw - MAP_W'(1)) ? sw - MAP_W'(1) : pos_x;
			py_q  <= (pos_y > sh - MAP_W'(1)) ? sh - MAP_W'(1) : pos_y;
			pct_q <= (percent > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : percent;
		end
	end

	// clear pass counter
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (cmd.clr_we) clr_cnt_q <= clr_cnt_q + AW'(1);
	end

	// grid memory write port
	logic [7:0]       mem [CELLS];
	logic             ld_ok, mem_we;
	logic [AW-1:0]    ld_addr, mem_waddr;
	logic [VAL_W-1:0] mem_wdata;

	always_comb begin
		ld_ok     = cmd.ld_we && (pos_x <= MAP_W'(gx)) && (pos_y <= MAP_W'(gy));
		ld_addr   = (AW'(pos_x) << MAX_Y_EXP) + AW'(pos_x) + AW'(pos_y);
		mem_we    = cmd.clr_we | ld_ok;
		mem_waddr = cmd.clr_we ? clr_cnt_q : ld_addr;
		mem_wdata = cmd.clr_we ? '0 : cell_value;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	// sample front: scaled coordinates, low cell, weights
	logic [SXW-1:0] sx_q, sy_q, lx_full, ly_full;
	logic [GXW-1:0] lx;
	logic [GYW-1:0] ly;
	logic [WW-1:0]  ex, ey;
	logic [WW-1:0]  wx0_q, wx1_q, wy0_q, wy1_q;
	logic [AW-1:0]  base_q;

	always_comb begin
		lx_full = sx_q >> FB;
		ly_full = sy_q >> FB;
		lx = (lx_full > SXW'(gx) - SXW'(1)) ? gx - GXW'(1) : lx_full[GXW-1:0];
		ly = (ly_full > SXW'(gy) - SXW'(1)) ? gy - GYW'(1) : ly_full[GYW-1:0];
		ex = WW'(sx_q - (SXW'(lx) << FB));
		ey = WW'(sy_q - (SXW'(ly) << FB));
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_mul) begin
			sx_q <= SXW'(x_step_q) * SXW'(px_q);
			sy_q <= SXW'(y_step_q) * SXW'(py_q);
		end
		if (cmd.smp_wt) begin
			wx0_q  <= WW'(FIX_ONE) - ex;
			wx1_q  <= ex;
			wy0_q  <= WW'(FIX_ONE) - ey;
			wy1_q  <= ey;
			base_q <= (AW'(lx) << MAX_Y_EXP) + AW'(lx) + AW'(ly);
		end
	end

	// corner read counter
	logic [1:0] rk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rk_q <= '0;
		else if (cmd.smp_wt) rk_q <= '0;
		else if (cmd.smp_rd) rk_q <= rk_q + 2'd1;
	end

	// scan walker over the grid for the percentile search
	logic [AW-1:0]  row_q;
	logic [GXW-1:0] cx_q;
	logic [GYW-1:0] cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
		end else if (cmd.scan_init) begin
			row_q <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
		end else if (cmd.scan_rd) begin
			if (cy_q == gy - GYW'(1)) begin
				cy_q  <= '0;
				cx_q  <= cx_q + GXW'(1);
				row_q <= row_q + AW'(STRIDE);
			end else begin
				cy_q <= cy_q + GYW'(1);
			end
		end
	end

	// grid memory read port
	logic [AW-1:0]    rd_addr, rk_off;
	logic [WW-1:0]    wsx, wsy;
	logic [VAL_W-1:0] rd_data_q;
	logic [PW-1:0]    wprod_s1;
	logic             rd_smp_s1, rd_pct_s1;

	always_comb begin
		case (rk_q)
			2'd0:    rk_off = '0;
			2'd1:    rk_off = AW'(STRIDE);
			2'd2:    rk_off = AW'(1);
			default: rk_off = AW'(STRIDE + 1);
		endcase
		wsx     = rk_q[0] ? wx1_q : wx0_q;
		wsy     = rk_q[1] ? wy1_q : wy0_q;
		rd_addr = cmd.smp_rd ? base_q + rk_off : row_q + AW'(cy_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_rd || cmd.scan_rd) rd_data_q <= mem[rd_addr];
		if (cmd.smp_rd) wprod_s1 <= PW'(wsx) * PW'(wsy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_smp_s1 <= 1'b0;
			rd_pct_s1 <= 1'b0;
		end else begin
			rd_smp_s1 <= cmd.smp_rd;
			rd_pct_s1 <= cmd.scan_rd;
		end
	end

	// blend accumulator
	logic [ACCW-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.smp_wt) acc_q <= '0;
		else if (rd_smp_s1) acc_q <= acc_q + ACCW'(wprod_s1) * ACCW'(rd_data_q);
	end

	// percentile search registers
	logic [VAL_W-1:0] est_q, lo_q, hi_q;
	logic [CW-1:0]    below_q;
	logic [14:0]      pct255;
	logic [EPW-1:0]   est_prod;
	logic [SHW-1:0]   share;
	logic             too_many;

	always_comb begin
		pct255   = (15'(pct_q) << 8) - 15'(pct_q);
		est_prod = EPW'(pct255) * EPW'(RECIP_100);
		share    = (SHW'(below_q) * SHW'(PCT_MAX)) >> (int'(xe_c) + int'(ye_c));
		too_many = share > SHW'(pct_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) below_q <= '0;
		else if (rd_pct_s1 && (rd_data_q < est_q)) below_q <= below_q + CW'(1);
		if (cmd.pct_init) begin
			est_q <= VAL_W'(est_prod >> RECIP_SH);
			lo_q  <= '0;
			hi_q  <= VAL_W'(HEIGHT_MAX);
		end else if (cmd.pct_upd) begin
			if (too_many) begin
				hi_q  <= est_q;
				est_q <= VAL_W'(({1'b0, est_q} + {1'b0, lo_q}) >> 1);
			end else begin
				lo_q  <= est_q;
				est_q <= VAL_W'(({1'b0, hi_q} + {1'b0, est_q}) >> 1);
			end
		end
	end

	// final blend scaling and output register
	logic [ACCW-1:0]  sum_full;
	logic [VAL_W-1:0] sum8, smp_res;
	logic [14:0]      scaled;
	logic             out_valid_q;
	logic [VAL_W-1:0] result_q;

	always_comb begin
		sum_full = acc_q >> (2 * FB);
		sum8     = (sum_full > ACCW'(HEIGHT_MAX)) ? VAL_W'(HEIGHT_MAX) : sum_full[VAL_W-1:0];
		scaled   = 15'(sum8) * 15'(PCT_MAX);
		smp_res  = pmode_q ? VAL_W'(scaled >> 8) : sum8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.smp_fin || cmd.pct_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_fin) result_q <= smp_res;
		else if (cmd.pct_out) result_q <= est_q;
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;

	// status to the controller
	always_comb begin
		stat.clr_last  = (clr_cnt_q == AW'(CELLS - 1));
		stat.div_busy  = (div_cnt_q != '0);
		stat.rk_last   = (rk_q == 2'd3);
		stat.scan_last = (cx_q == gx - GXW'(1)) && (cy_q == gy - GYW'(1));
		stat.est_eq_lo = (est_q == lo_q);
		stat.out_free  = !out_valid_q || !out_stall;
	end

endmodule

/* rtl/core/heightmap_bilinear_sampler_unit.sv */
// sample: after acceptance the multiply, weight, corner read, accumulate and finish states
// reach the output register (one memory read per grid corner); finish waits out a stall
// percentile: init, then per binary search step a check, a full grid scan, a drain and
// an update, then output; one transaction at a time; the single-port grid scan sets the
// percentile time; reset: a clearing pass zeroes every grid cell, then step division
// stalls input; each config write repeats it; top level of the heightmap sampler
`include "assert_macros.svh"
module heightmap_bilinear_sampler_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [hbs_pkg::OP_W-1:0]    op,
	input  logic [hbs_pkg::MAP_W-1:0]   pos_x,
	input  logic [hbs_pkg::MAP_W-1:0]   pos_y,
	input  logic [hbs_pkg::VAL_W-1:0]   cell_value,
	input  logic [hbs_pkg::PCT_W-1:0]   percent,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hbs_pkg::VAL_W-1:0]   result_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hbs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [hbs_pkg::CDAT_W-1:0]  cfg_data
);
	import hbs_pkg::*;

	hbs_cmd_t  cmd;
	hbs_stat_t stat;

	// controller
	hbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// datapath
	hbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.cell_value   (cell_value),
		.percent      (percent),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_value (result_value)
	);

	// checks
	`HBS_ASSERT_IMPLY(a_no_accept_div, clk, arst_n, stat.div_busy, in_stall)
	`HBS_ASSERT_NEXT(a_cfg_blocks_in, clk, arst_n, cfg_valid && cfg_ready, in_stall)
	`HBS_ASSERT_IMPLY(a_no_accept_clr, clk, arst_n, cmd.clr_we, in_stall && !cmd.ld_we)

endmodule
